>>> sv/p521fas_pkg.sv
// Shared types and constants for the p521 field add/subtract/negate block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package p521fas_pkg;

	localparam int LIMB_W      = 64;
	localparam int LIMBS_DEF   = 9;
	localparam int PRIME_BITS  = 521;
	localparam int CMD_W       = 2;
	localparam int LIMB_IDX_W  = 4;

	// Operation codes; the spare code is handled as negate.
	localparam logic [CMD_W-1:0] OP_ADD = 2'd0;
	localparam logic [CMD_W-1:0] OP_SUB = 2'd1;
	localparam logic [CMD_W-1:0] OP_NEG = 2'd2;

	typedef enum logic [1:0] {
		S_LOAD,
		S_ADD,
		S_FOLD,
		S_EMIT
	} state_t;

	// Control of the shared limb adder.
	typedef struct packed {
		logic cin;
		logic top;
	} alu_ctl_t;

endpackage

`default_nettype wire

>>> sv/p521fas_if.sv
// Valid/ready channel interfaces for operand limbs and result limbs.
// Depends on p521fas_pkg for field widths.
`default_nettype none

interface p521fas_in_if import p521fas_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic [LIMB_W-1:0]    left_limb;
	logic [LIMB_W-1:0]    right_limb;

	modport source (output valid, cmd, left_limb, right_limb, input ready);
	modport sink   (input valid, cmd, left_limb, right_limb, output ready);
endinterface

interface p521fas_out_if import p521fas_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LIMB_W-1:0]     result_limb;
	logic [LIMB_IDX_W-1:0] limb_pos;
	logic                  last_limb;

	modport source (output valid, result_limb, limb_pos, last_limb, input ready);
	modport sink   (input valid, result_limb, limb_pos, last_limb, output ready);
endinterface

`default_nettype wire

>>> sv/p521fas_alu.sv
// Shared limb adder with carry in/out and all-ones detection.
// Depends on p521fas_pkg for the control struct.
`default_nettype none

module p521fas_alu import p521fas_pkg::*; #(
	parameter int WIDTH    = LIMB_W,
	parameter int TOP_BITS = PRIME_BITS - LIMB_W * (LIMBS_DEF - 1)
) (
	input  wire logic [WIDTH-1:0] a,
	input  wire logic [WIDTH-1:0] b,
	input  wire alu_ctl_t         ctl,
	output logic [WIDTH-1:0]      sum,
	output logic                  cout,
	output logic                  ones
);

	localparam logic [WIDTH-1:0] TOP_MASK = {{(WIDTH - TOP_BITS){1'b0}}, {TOP_BITS{1'b1}}};

	logic [WIDTH-1:0] a_m;
	logic [WIDTH-1:0] b_m;
	logic [WIDTH:0]   sum_full;

	// The top limb only carries the bits below the prime's width.
	assign a_m      = ctl.top ? (a & TOP_MASK) : a;
	assign b_m      = ctl.top ? (b & TOP_MASK) : b;
	assign sum_full = {1'b0, a_m} + {1'b0, b_m} + {{WIDTH{1'b0}}, ctl.cin};

	always_comb begin
		if (ctl.top) begin
			sum  = sum_full[WIDTH-1:0] & TOP_MASK;
			cout = sum_full[TOP_BITS];
			ones = &sum_full[TOP_BITS-1:0];
		end else begin
			sum  = sum_full[WIDTH-1:0];
			cout = sum_full[WIDTH];
			ones = &sum_full[WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

>>> sv/p521_field_add_sub_neg.sv
// Top level of the limb-serial add/subtract/negate unit modulo 2^521-1.
// Depends on p521fas_pkg, the channel interfaces and p521fas_alu.
//
// Usage: the operand channel takes one item per limb, least significant
// limb first, nine items per element. The command is taken from the first
// item of each group: add, subtract, or negate (the spare code negates).
// Bits above bit 8 of the top limb are dropped on load.
// After the ninth item is accepted the block runs two passes over the
// stored limbs with one shared 64-bit adder: a carry pass and an
// end-around fold pass that also checks for the all-ones value. It then
// sends nine result items, each with its limb index and a last flag on
// limb eight. The single adder steps one limb per cycle through the carry
// and fold passes; the load and send phases step one limb per accepted
// item. No limbs of a new element are taken until the last result limb
// of the previous element has entered the output register.
// The operand channel is ready only while limbs are being loaded. The
// result channel has an output register: a stalled receiver holds the
// send phase, and the final limb may wait there while the next element
// is loaded.
// Reset clears the sequencer, the limb counter and the output valid flag;
// the limb stores hold no reset value and are always written before use.
`default_nettype none

module p521_field_add_sub_neg import p521fas_pkg::*; #(
	parameter int LIMBS = LIMBS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	p521fas_in_if.sink   operand,
	p521fas_out_if.source result
);

	localparam int IDX_W    = $clog2(LIMBS);
	localparam int TOP_BITS = PRIME_BITS - LIMB_W * (LIMBS - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIMBS - 1);
	localparam logic [LIMB_W-1:0] TOP_MASK =
		{{(LIMB_W - TOP_BITS){1'b0}}, {TOP_BITS{1'b1}}};

	// Operand and result limb stores.
	logic [LIMB_W-1:0] x_q [LIMBS];
	logic [LIMB_W-1:0] y_q [LIMBS];
	logic [LIMB_W-1:0] r_q [LIMBS];

	state_t            state_q;
	state_t            state_d;
	logic [IDX_W-1:0]  k_q;
	logic [CMD_W-1:0]  op_q;
	logic              carry_q;
	logic              allones_q;
	logic              k_last;

	// Output register.
	logic                  ov_q;
	logic [LIMB_W-1:0]     res_q;
	logic [LIMB_IDX_W-1:0] idx_q;
	logic                  last_q;

	// Sequencer outputs.
	logic              in_ready;
	logic              in_take;
	logic              out_take;
	logic [LIMB_W-1:0] alu_a;
	logic [LIMB_W-1:0] alu_b;
	alu_ctl_t          alu_ctl;
	logic [LIMB_W-1:0] alu_sum;
	logic              alu_cout;
	logic              alu_ones;

	assign k_last  = (k_q == LAST_IDX);
	assign in_take = in_ready && operand.valid;

	p521fas_alu #(
		.WIDTH    (LIMB_W),
		.TOP_BITS (TOP_BITS)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.ctl  (alu_ctl),
		.sum  (alu_sum),
		.cout (alu_cout),
		.ones (alu_ones)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_take && k_last) state_d = S_ADD;
			end
			S_ADD: begin
				if (k_last) state_d = S_FOLD;
			end
			S_FOLD: begin
				if (k_last) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_take && k_last) state_d = S_LOAD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	// Sequencer outputs. Subtract and negate use the fact that p minus a
	// value is its ones' complement within 521 bits, so every operation is
	// one addition followed by an end-around fold.
	always_comb begin
		in_ready    = 1'b0;
		out_take    = 1'b0;
		alu_a       = '0;
		alu_b       = '0;
		alu_ctl.cin = carry_q;
		alu_ctl.top = k_last;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
			end
			S_ADD: begin
				case (op_q)
					OP_ADD: begin
						alu_a = x_q[k_q];
						alu_b = y_q[k_q];
					end
					OP_SUB: begin
						alu_a = x_q[k_q];
						alu_b = ~y_q[k_q];
					end
					default: begin
						alu_a = '0;
						alu_b = ~x_q[k_q];
					end
				endcase
			end
			S_FOLD: begin
				alu_a = r_q[k_q];
			end
			S_EMIT: begin
				out_take = !ov_q || result.ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			k_q       <= '0;
			op_q      <= OP_ADD;
			carry_q   <= 1'b0;
			allones_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_LOAD: begin
					if (in_take) begin
						if (k_q == '0) op_q <= operand.cmd;
						k_q     <= k_last ? '0 : k_q + 1'b1;
						carry_q <= 1'b0;
					end
				end
				S_ADD: begin
					k_q       <= k_last ? '0 : k_q + 1'b1;
					carry_q   <= alu_cout;
					allones_q <= 1'b1;
				end
				S_FOLD: begin
					k_q       <= k_last ? '0 : k_q + 1'b1;
					carry_q   <= alu_cout;
					allones_q <= allones_q && alu_ones;
				end
				S_EMIT: begin
					if (out_take) k_q <= k_last ? '0 : k_q + 1'b1;
				end
				default: k_q <= '0;
			endcase
			if (out_take) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Limb stores and output payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q[k_q] <= k_last ? (operand.left_limb & TOP_MASK) : operand.left_limb;
			y_q[k_q] <= k_last ? (operand.right_limb & TOP_MASK) : operand.right_limb;
		end
		if (state_q == S_ADD || state_q == S_FOLD) begin
			r_q[k_q] <= alu_sum;
		end
		if (out_take) begin
			res_q  <= allones_q ? '0 : r_q[k_q];
			idx_q  <= LIMB_IDX_W'(k_q);
			last_q <= k_last;
		end
	end

	assign operand.ready      = in_ready;
	assign result.valid       = ov_q;
	assign result.result_limb = res_q;
	assign result.limb_pos    = idx_q;
	assign result.last_limb   = last_q;

`ifndef SYNTHESIS
	// Operands never exceed p, so the fold cannot carry out of the top limb.
	a_fold_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FOLD && k_last) |-> !alu_cout)
		else $error("fold pass carried out of the top limb");

	// The carry pass hands over to the fold pass starting at limb zero.
	a_add_to_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD && k_last) |=> (state_q == S_FOLD && k_q == '0))
		else $error("carry pass did not hand over to fold pass");

	// A folded value equal to p is sent as zero.
	a_p_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && allones_q) |=> (result.result_limb == '0))
		else $error("all-ones result not replaced by zero");

	// Result limbs of one element leave in order.
	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && k_q != '0) |-> (idx_q == LIMB_IDX_W'(k_q - 1'b1)))
		else $error("result limb index out of sequence");
`endif

endmodule

`default_nettype wire
